[sv/clpr_pkg.sv]
// Shared types and constants for the cluster label path replay block.
package clpr_pkg;

  // Fixed field widths of the request, result and configuration items.
  localparam int unsigned REQ_TYPE_W  = 2;
  localparam int unsigned POINT_IDX_W = 6;
  localparam int unsigned LABEL_W     = 9;
  localparam int unsigned EVENT_IDX_W = 8;
  localparam int unsigned LAMBDA_W    = 32;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned CHILD_W     = 10;
  localparam int unsigned NPTS_W      = 7;
  localparam int unsigned NEVT_W      = 9;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 9;

  // Request codes.
  localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_LABEL = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_LOAD_EVENT = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_QUERY      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_EVENTS = 1'b1;

  // Configuration reset values.
  localparam logic [NPTS_W-1:0] NUM_POINTS_RST = 7'd64;
  localparam logic [NEVT_W-1:0] NUM_EVENTS_RST = 9'd0;

  // An applied event k writes label k plus this offset.
  localparam logic [LABEL_W-1:0] LABEL_OFFSET = 9'd2;

  // Child link that marks a single-point event.
  localparam logic [CHILD_W-1:0] CHILD_SINGLE = 10'h3FF;

  // One request item.
  typedef struct packed {
    logic [REQ_TYPE_W-1:0]  req_type;
    logic [POINT_IDX_W-1:0] point_index;
    logic [LABEL_W-1:0]     label_value;
    logic [EVENT_IDX_W-1:0] event_index;
    logic [LAMBDA_W-1:0]    event_lambda_in;
    logic [POS_W-1:0]       event_start_in;
    logic [POS_W-1:0]       event_end_in;
    logic [CHILD_W-1:0]     event_child_in;
    logic [LAMBDA_W-1:0]    query_lambda;
  } clpr_req_t;

  // One entry of the event table.
  typedef struct packed {
    logic [LAMBDA_W-1:0] lambda;
    logic [POS_W-1:0]    start_pos;
    logic [POS_W-1:0]    end_pos;
    logic [CHILD_W-1:0]  child;
  } clpr_event_t;

  // One result item.
  typedef struct packed {
    logic [LABEL_W-1:0]     label;
    logic [POINT_IDX_W-1:0] out_point_index;
    logic                   last;
  } clpr_res_t;

  // Tag that travels with a label memory read during emission.
  typedef struct packed {
    logic                   vld;
    logic [POINT_IDX_W-1:0] idx;
    logic                   last;
  } clpr_tag_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_CHK,
    ST_END,
    ST_FILL,
    ST_EMIT
  } clpr_state_e;

endpackage

[sv/clpr_req_if.sv]
// Request channel interface: valid, ready and the request fields.
interface clpr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  point_index;
  logic [8:0]  label_value;
  logic [7:0]  event_index;
  logic [31:0] event_lambda_in;
  logic [6:0]  event_start_in;
  logic [6:0]  event_end_in;
  logic signed [9:0] event_child_in;
  logic [31:0] query_lambda;

  modport source (
    output valid, req_type, point_index, label_value, event_index,
           event_lambda_in, event_start_in, event_end_in, event_child_in,
           query_lambda,
    input  ready
  );

  modport sink (
    input  valid, req_type, point_index, label_value, event_index,
           event_lambda_in, event_start_in, event_end_in, event_child_in,
           query_lambda,
    output ready
  );
endinterface

[sv/clpr_res_if.sv]
// Result channel interface: valid, ready and the label fields.
interface clpr_res_if;
  logic       valid;
  logic       ready;
  logic [8:0] label;
  logic [5:0] out_point_index;
  logic       last;

  modport source (
    output valid, label, out_point_index, last,
    input  ready
  );

  modport sink (
    input  valid, label, out_point_index, last,
    output ready
  );
endinterface

[sv/clpr_label_mem.sv]
// Label memory: one write port and one registered read port.
module clpr_label_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [clpr_pkg::LABEL_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [clpr_pkg::LABEL_W-1:0] rdata_o
);

  logic [clpr_pkg::LABEL_W-1:0] mem [DEPTH];
  logic [clpr_pkg::LABEL_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/clpr_event_mem.sv]
// Event table memory: one write port and one registered read port.
module clpr_event_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  clpr_pkg::clpr_event_t wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output clpr_pkg::clpr_event_t rdata_o
);

  clpr_pkg::clpr_event_t mem [DEPTH];
  clpr_pkg::clpr_event_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/clpr_out_buf.sv]
// Two-entry result buffer fed by label memory reads, with issue credit.
module clpr_out_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  clpr_pkg::clpr_tag_t          tag_i,
  input  logic [clpr_pkg::LABEL_W-1:0] label_i,
  output logic                         can_issue_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output clpr_pkg::clpr_res_t          res_o
);

  clpr_pkg::clpr_res_t buf_q [2];
  logic [1:0]          cnt_q, cnt_d;
  logic                head_q, head_d;
  logic                tail;
  logic                pop;

  assign pop  = res_valid_o && res_ready_i;
  assign tail = head_q ^ cnt_q[0];

  // Occupancy and head pointer.
  always_comb begin
    cnt_d  = cnt_q + {1'b0, tag_i.vld} - {1'b0, pop};
    head_d = head_q ^ pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      head_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  // A landing read fills the slot after the current occupants.
  always_ff @(posedge clk_i) begin
    if (tag_i.vld) begin
      buf_q[tail] <= '{label: label_i, out_point_index: tag_i.idx, last: tag_i.last};
    end
  end

  // A read issued now lands next cycle; keep at most two items in the buffer.
  assign can_issue_o = (cnt_d <= 2'd1);
  assign res_valid_o = (cnt_q != 2'd0);
  assign res_o       = buf_q[head_q];

endmodule

[sv/clpr_ctrl.sv]
// Sequencer: loads, event replay over the label memory, and label emission.
module clpr_ctrl #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned MAX_EVENTS = 256,
  parameter int unsigned PA_W       = 6,
  parameter int unsigned EA_W       = 8,
  parameter int unsigned PTR_W      = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [clpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [clpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  clpr_pkg::clpr_req_t             req_i,
  output logic                            lbl_we_o,
  output logic [PA_W-1:0]                 lbl_waddr_o,
  output logic [clpr_pkg::LABEL_W-1:0]    lbl_wdata_o,
  output logic                            lbl_re_o,
  output logic [PA_W-1:0]                 lbl_raddr_o,
  output logic                            ev_we_o,
  output logic [EA_W-1:0]                 ev_waddr_o,
  output clpr_pkg::clpr_event_t           ev_wdata_o,
  output logic                            ev_re_o,
  output logic [EA_W-1:0]                 ev_raddr_o,
  input  clpr_pkg::clpr_event_t           ev_rdata_i,
  input  logic                            can_issue_i,
  output clpr_pkg::clpr_tag_t             tag_o
);

  clpr_pkg::clpr_state_e state_q, state_d;

  logic [clpr_pkg::NPTS_W-1:0]   num_points_q;
  logic [clpr_pkg::NEVT_W-1:0]   num_events_q;
  logic [PTR_W-1:0]              ptr_q, ptr_d;
  logic [clpr_pkg::LAMBDA_W-1:0] qlam_q, qlam_d;
  logic [clpr_pkg::POS_W-1:0]    s_q, s_d;
  logic [clpr_pkg::POS_W-1:0]    e_q, e_d;
  logic [clpr_pkg::POS_W:0]      j_q, j_d;
  logic [clpr_pkg::NPTS_W-1:0]   m_q, m_d;
  clpr_pkg::clpr_tag_t           tag_q, tag_d;

  logic [clpr_pkg::NPTS_W-1:0]   np;
  logic [PTR_W-1:0]              ne;
  logic                          accept;
  logic                          child_single;
  logic                          child_link;
  logic [clpr_pkg::LABEL_W-1:0]  cur_label;
  clpr_pkg::clpr_state_e         after_replay;

  // Effective point and event counts.
  assign np = (32'(num_points_q) > 32'(MAX_POINTS)) ? clpr_pkg::NPTS_W'(MAX_POINTS)
                                                    : num_points_q;
  assign ne = (32'(num_events_q) > 32'(MAX_EVENTS)) ? PTR_W'(MAX_EVENTS)
                                                    : PTR_W'(num_events_q);

  assign req_ready_o = (state_q == clpr_pkg::ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // Child link decode of the event just read.
  assign child_single = (ev_rdata_i.child == clpr_pkg::CHILD_SINGLE);
  assign child_link   = !ev_rdata_i.child[clpr_pkg::CHILD_W-1]
                        && (ev_rdata_i.child != '0)
                        && (32'(ev_rdata_i.child) <= 32'(MAX_EVENTS));

  assign cur_label    = clpr_pkg::LABEL_W'(ptr_q) + clpr_pkg::LABEL_OFFSET;
  assign after_replay = (np == '0) ? clpr_pkg::ST_IDLE : clpr_pkg::ST_EMIT;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= clpr_pkg::NUM_POINTS_RST;
      num_events_q <= clpr_pkg::NUM_EVENTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clpr_pkg::CFG_NUM_POINTS: num_points_q <= clpr_pkg::NPTS_W'(cfg_data_i);
        clpr_pkg::CFG_NUM_EVENTS: num_events_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state and memory control.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    qlam_d      = qlam_q;
    s_d         = s_q;
    e_d         = e_q;
    j_d         = j_q;
    m_d         = m_q;
    tag_d       = '0;
    lbl_we_o    = 1'b0;
    lbl_waddr_o = PA_W'(req_i.point_index);
    lbl_wdata_o = req_i.label_value;
    lbl_re_o    = 1'b0;
    lbl_raddr_o = PA_W'(m_q);
    ev_we_o     = 1'b0;
    ev_waddr_o  = EA_W'(req_i.event_index);
    ev_wdata_o  = '{lambda:    req_i.event_lambda_in,
                    start_pos: req_i.event_start_in,
                    end_pos:   req_i.event_end_in,
                    child:     req_i.event_child_in};
    ev_re_o     = 1'b0;
    ev_raddr_o  = EA_W'(ptr_q);

    unique case (state_q)
      clpr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            clpr_pkg::REQ_LOAD_LABEL: begin
              lbl_we_o = (32'(req_i.point_index) < 32'(MAX_POINTS));
              ptr_d    = '0;
            end
            clpr_pkg::REQ_LOAD_EVENT: begin
              ev_we_o = (32'(req_i.event_index) < 32'(MAX_EVENTS));
              ptr_d   = '0;
            end
            clpr_pkg::REQ_QUERY: begin
              qlam_d  = req_i.query_lambda;
              state_d = clpr_pkg::ST_EV_RD;
            end
            default: ;
          endcase
        end
      end

      // Fetch the next pending event, or end the replay: emission, or idle with no points.
      clpr_pkg::ST_EV_RD: begin
        m_d = '0;
        if (ptr_q < ne) begin
          ev_re_o = 1'b1;
          state_d = clpr_pkg::ST_EV_CHK;
        end else begin
          state_d = after_replay;
        end
      end

      // Compare lambdas and decode the event's range.
      clpr_pkg::ST_EV_CHK: begin
        m_d = '0;
        if (qlam_q < ev_rdata_i.lambda) begin
          s_d = ev_rdata_i.start_pos;
          if (child_single) begin
            e_d     = ev_rdata_i.start_pos;
            j_d     = {1'b0, ev_rdata_i.start_pos};
            state_d = clpr_pkg::ST_FILL;
          end else if (child_link) begin
            ev_re_o    = 1'b1;
            ev_raddr_o = EA_W'(ev_rdata_i.child - clpr_pkg::CHILD_W'(1));
            state_d    = clpr_pkg::ST_END;
          end else begin
            ptr_d   = ptr_q + PTR_W'(1);
            state_d = clpr_pkg::ST_EV_RD;
          end
        end else begin
          state_d = after_replay;
        end
      end

      // The child's end bounds the range.
      clpr_pkg::ST_END: begin
        e_d     = ev_rdata_i.end_pos;
        j_d     = {1'b0, s_q};
        state_d = clpr_pkg::ST_FILL;
      end

      // Write one point of the range per cycle; stop past the range or the points.
      clpr_pkg::ST_FILL: begin
        if ((j_q <= {1'b0, e_q}) && (j_q <= {1'b0, np})) begin
          lbl_we_o    = (j_q != '0);
          lbl_waddr_o = PA_W'(j_q - 8'd1);
          lbl_wdata_o = cur_label;
          j_d         = j_q + 8'd1;
        end else begin
          ptr_d   = ptr_q + PTR_W'(1);
          state_d = clpr_pkg::ST_EV_RD;
        end
      end

      // Read the labels in order as buffer space allows.
      clpr_pkg::ST_EMIT: begin
        if (can_issue_i) begin
          lbl_re_o   = 1'b1;
          tag_d.vld  = 1'b1;
          tag_d.idx  = clpr_pkg::POINT_IDX_W'(m_q);
          tag_d.last = (m_q + 7'd1 == np);
          m_d        = m_q + 7'd1;
          if (m_q + 7'd1 == np) begin
            state_d = clpr_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = clpr_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clpr_pkg::ST_IDLE;
      ptr_q   <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      tag_q   <= tag_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    qlam_q <= qlam_d;
    s_q    <= s_d;
    e_q    <= e_d;
    j_q    <= j_d;
    m_q    <= m_d;
  end

  assign tag_o = tag_q;

endmodule

[sv/cluster_label_path_replay_top.sv]
// Top level of the cluster label path replay block.
//
//   Port     Direction  Handshake       Moves
//   req_i    in         valid/ready     load-label, load-event or query item
//   res_o    out        valid/ready     one label item per point, last flagged
//   cfg_*    in         write enable    num_points (index 0), num_events (1)
//
// A load item leaves the block idle, so loads can follow back to back. A query tests
// each pending event in ST_EV_RD and ST_EV_CHK and fetches a child's end in ST_END;
// an event that writes walks its range in ST_FILL at one point per cycle, stopping at
// num_points. Then num_points labels follow at one per cycle through the label read
// port while the output buffer has room. Reset puts the state machine, the event
// pointer and the configuration to reset values. The next item is taken once the last
// label read is issued; a stalled result side holds emission through a two-entry buffer.
module cluster_label_path_replay_top #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned MAX_EVENTS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [clpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [clpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  clpr_req_if.sink                        req_i,
  clpr_res_if.source                      res_o
);

  localparam int unsigned PA_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned EA_W  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned PTR_W = $clog2(MAX_EVENTS + 1);

  clpr_pkg::clpr_req_t          req;
  clpr_pkg::clpr_res_t          res;
  clpr_pkg::clpr_tag_t          tag;
  clpr_pkg::clpr_event_t        ev_wdata;
  clpr_pkg::clpr_event_t        ev_rdata;
  logic                         lbl_we;
  logic [PA_W-1:0]              lbl_waddr;
  logic [clpr_pkg::LABEL_W-1:0] lbl_wdata;
  logic                         lbl_re;
  logic [PA_W-1:0]              lbl_raddr;
  logic [clpr_pkg::LABEL_W-1:0] lbl_rdata;
  logic                         ev_we;
  logic [EA_W-1:0]              ev_waddr;
  logic                         ev_re;
  logic [EA_W-1:0]              ev_raddr;
  logic                         can_issue;
  logic                         res_valid;

  // Gather the request fields.
  assign req = '{req_type:        req_i.req_type,
                 point_index:     req_i.point_index,
                 label_value:     req_i.label_value,
                 event_index:     req_i.event_index,
                 event_lambda_in: req_i.event_lambda_in,
                 event_start_in:  req_i.event_start_in,
                 event_end_in:    req_i.event_end_in,
                 event_child_in:  req_i.event_child_in,
                 query_lambda:    req_i.query_lambda};

  clpr_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_EVENTS (MAX_EVENTS),
    .PA_W       (PA_W),
    .EA_W       (EA_W),
    .PTR_W      (PTR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .lbl_we_o    (lbl_we),
    .lbl_waddr_o (lbl_waddr),
    .lbl_wdata_o (lbl_wdata),
    .lbl_re_o    (lbl_re),
    .lbl_raddr_o (lbl_raddr),
    .ev_we_o     (ev_we),
    .ev_waddr_o  (ev_waddr),
    .ev_wdata_o  (ev_wdata),
    .ev_re_o     (ev_re),
    .ev_raddr_o  (ev_raddr),
    .ev_rdata_i  (ev_rdata),
    .can_issue_i (can_issue),
    .tag_o       (tag)
  );

  clpr_label_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (PA_W)
  ) u_label_mem (
    .clk_i   (clk_i),
    .we_i    (lbl_we),
    .waddr_i (lbl_waddr),
    .wdata_i (lbl_wdata),
    .re_i    (lbl_re),
    .raddr_i (lbl_raddr),
    .rdata_o (lbl_rdata)
  );

  clpr_event_mem #(
    .DEPTH (MAX_EVENTS),
    .AW    (EA_W)
  ) u_event_mem (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .re_i    (ev_re),
    .raddr_i (ev_raddr),
    .rdata_o (ev_rdata)
  );

  clpr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .label_i     (lbl_rdata),
    .can_issue_o (can_issue),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  // Drive the result channel.
  assign res_o.valid           = res_valid;
  assign res_o.label           = res.label;
  assign res_o.out_point_index = res.out_point_index;
  assign res_o.last            = res.last;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the cluster label path replay block.
module tb;
  import clpr_pkg::*;

  localparam int unsigned N_POINTS       = 64;
  localparam int unsigned N_EVENTS       = 256;
  localparam int unsigned RANDOM_ITEMS   = 75;
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  // Worst case cycles spent on one event: test, child fetch and a full range of writes.
  localparam int unsigned EVENT_CYCLES   = 70;
  localparam int unsigned SETTLE_CYCLES  = 16;

  // Request code that the block ignores.
  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED    = 2'd3;
  // Child link of zero: the event is applied but writes nothing.
  localparam logic [CHILD_W-1:0]    CHILD_NO_LINK = '0;

  // Scoreboard: replays the label path on its own copy of the state and
  // holds the label items that the block still owes.
  class label_replay_sb;
    logic [LABEL_W-1:0] point_label [N_POINTS];
    clpr_event_t        event_tbl [N_EVENTS];
    int unsigned        event_ptr;
    logic [NPTS_W-1:0]  cfg_points;
    logic [NEVT_W-1:0]  cfg_events;
    clpr_res_t          owed_labels [$];
    int unsigned        errors;
    int unsigned        labels_checked;
    int unsigned        requests_seen;
    int unsigned        queries_seen;

    function new();
      cfg_points     = NUM_POINTS_RST;
      cfg_events     = NUM_EVENTS_RST;
      event_ptr      = 0;
      errors         = 0;
      labels_checked = 0;
      requests_seen  = 0;
      queries_seen   = 0;
    endfunction

    function void write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_NUM_POINTS) begin
        cfg_points = data[NPTS_W-1:0];
      end else begin
        cfg_events = data[NEVT_W-1:0];
      end
    endfunction

    function int unsigned pending();
      return owed_labels.size();
    endfunction

    // Apply merge event k: write its label over the run of points it covers.
    function void replay_event(int unsigned k, int unsigned np);
      logic [LABEL_W-1:0] lbl;
      int                 child;
      int                 first;
      int                 stop;
      lbl   = LABEL_OFFSET + LABEL_W'(k);
      first = int'(event_tbl[k].start_pos);
      if (event_tbl[k].child == CHILD_SINGLE) begin
        stop = first;
      end else begin
        child = int'($signed(event_tbl[k].child));
        if (child >= 1 && child <= int'(N_EVENTS)) begin
          stop = int'(event_tbl[child-1].end_pos);
        end else begin
          stop = first - 1;
        end
      end
      // Positions are one-based; anything outside the tracked points is dropped.
      for (int j = first; j <= stop; j++) begin
        if (j >= 1 && j - 1 < int'(np)) point_label[j-1] = lbl;
      end
    endfunction

    function void note_request(clpr_req_t r);
      int unsigned np;
      int unsigned ne;
      clpr_res_t   item;
      requests_seen++;
      case (r.req_type)
        REQ_LOAD_LABEL: begin
          point_label[r.point_index] = r.label_value;
          event_ptr = 0;
        end
        REQ_LOAD_EVENT: begin
          event_tbl[r.event_index].lambda    = r.event_lambda_in;
          event_tbl[r.event_index].start_pos = r.event_start_in;
          event_tbl[r.event_index].end_pos   = r.event_end_in;
          event_tbl[r.event_index].child     = r.event_child_in;
          event_ptr = 0;
        end
        REQ_QUERY: begin
          queries_seen++;
          np = (cfg_points > N_POINTS) ? N_POINTS : cfg_points;
          ne = (cfg_events > N_EVENTS) ? N_EVENTS : cfg_events;
          // Apply pending events while their lambda is strictly above the query.
          while (event_ptr < ne && r.query_lambda < event_tbl[event_ptr].lambda) begin
            replay_event(event_ptr, np);
            event_ptr++;
          end
          for (int unsigned m = 0; m < np; m++) begin
            item.label           = point_label[m];
            item.out_point_index = POINT_IDX_W'(m);
            item.last            = (m + 1 == np);
            owed_labels.push_back(item);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void flag(string what, logic [31:0] want_v, logic [31:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    endfunction

    function void check_label(clpr_res_t got);
      clpr_res_t want;
      labels_checked++;
      if (owed_labels.size() == 0) begin
        errors++;
        $display("%0t: label item with nothing expected, expected none, actual %0d/%0d/%0d",
                 $time, got.label, got.out_point_index, got.last);
        return;
      end
      want = owed_labels.pop_front();
      if (got.label !== want.label) flag("label", want.label, got.label);
      if (got.out_point_index !== want.out_point_index)
        flag("out_point_index", want.out_point_index, got.out_point_index);
      if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  clpr_req_if req_if ();
  clpr_res_if res_if ();

  cluster_label_path_replay_top #(
    .MAX_POINTS(N_POINTS),
    .MAX_EVENTS(N_EVENTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  label_replay_sb sb;
  bit             ev_written [N_EVENTS];
  int unsigned    burst_left;
  bit             calm;
  int unsigned    counted_items;
  int unsigned    tail_cycles;
  int unsigned    cur_points;
  int unsigned    cur_events;
  int unsigned    settings_used;
  int unsigned    quiet_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side readiness: a pattern of its own that changes every so often.
  initial begin : rx_pattern
    int unsigned mode;
    int unsigned span;
    res_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       res_if.ready = 1'b1;
          1:       res_if.ready = ($urandom_range(0, 1) == 1);
          2:       res_if.ready = ($urandom_range(0, 7) != 0);
          default: res_if.ready = ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  // Acceptance monitor and watchdog. Results are checked before the request of
  // the same edge is noted, since they always belong to earlier queries.
  always @(posedge clk_i) begin : acceptance_monitor
    clpr_res_t got;
    clpr_req_t seen;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (res_if.valid && res_if.ready) begin
        got.label           = res_if.label;
        got.out_point_index = res_if.out_point_index;
        got.last            = res_if.last;
        sb.check_label(got);
        moved = 1'b1;
      end
      if (req_if.valid && req_if.ready) begin
        seen.req_type        = req_if.req_type;
        seen.point_index     = req_if.point_index;
        seen.label_value     = req_if.label_value;
        seen.event_index     = req_if.event_index;
        seen.event_lambda_in = req_if.event_lambda_in;
        seen.event_start_in  = req_if.event_start_in;
        seen.event_end_in    = req_if.event_end_in;
        seen.event_child_in  = req_if.event_child_in;
        seen.query_lambda    = req_if.query_lambda;
        sb.note_request(seen);
        moved = 1'b1;
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic clpr_req_t rand_fields();
    clpr_req_t r;
    r.req_type        = REQ_UNUSED;
    r.point_index     = POINT_IDX_W'($urandom());
    r.label_value     = LABEL_W'($urandom());
    r.event_index     = EVENT_IDX_W'($urandom());
    r.event_lambda_in = $urandom();
    r.event_start_in  = POS_W'($urandom());
    r.event_end_in    = POS_W'($urandom());
    r.event_child_in  = CHILD_W'($urandom());
    r.query_lambda    = $urandom();
    return r;
  endfunction

  // Child link that only ever points at an event entry that holds data.
  function automatic logic [CHILD_W-1:0] pick_child(int unsigned limit);
    int unsigned sel;
    int unsigned idx;
    sel = $urandom_range(0, 19);
    if (sel < 5) return CHILD_SINGLE;
    if (sel < 7) return CHILD_NO_LINK;
    if (sel < 9) begin
      idx = $urandom_range(0, N_EVENTS - 1);
      while (!ev_written[idx]) idx = (idx + 1) % N_EVENTS;
      return CHILD_W'(idx + 1);
    end
    return CHILD_W'($urandom_range(1, limit));
  endfunction

  // Send one request item, in bursts with random gaps unless calm.
  task automatic push_item(input clpr_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.req_type        = r.req_type;
    req_if.point_index     = r.point_index;
    req_if.label_value     = r.label_value;
    req_if.event_index     = r.event_index;
    req_if.event_lambda_in = r.event_lambda_in;
    req_if.event_start_in  = r.event_start_in;
    req_if.event_end_in    = r.event_end_in;
    req_if.event_child_in  = r.event_child_in;
    req_if.query_lambda    = r.query_lambda;
    req_if.valid           = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic load_label(input int unsigned p, input int unsigned v);
    clpr_req_t r;
    r             = rand_fields();
    r.req_type    = REQ_LOAD_LABEL;
    r.point_index = POINT_IDX_W'(p);
    r.label_value = LABEL_W'(v);
    push_item(r);
    counted_items++;
    tail_cycles = 0;
  endtask

  task automatic load_event(input int unsigned idx, input logic [LAMBDA_W-1:0] lam,
                            input int unsigned s, input int unsigned e,
                            input logic [CHILD_W-1:0] c);
    clpr_req_t r;
    r                 = rand_fields();
    r.req_type        = REQ_LOAD_EVENT;
    r.event_index     = EVENT_IDX_W'(idx);
    r.event_lambda_in = lam;
    r.event_start_in  = POS_W'(s);
    r.event_end_in    = POS_W'(e);
    r.event_child_in  = c;
    push_item(r);
    ev_written[idx] = 1'b1;
    counted_items++;
    tail_cycles = 0;
  endtask

  task automatic query(input logic [LAMBDA_W-1:0] q);
    clpr_req_t r;
    r              = rand_fields();
    r.req_type     = REQ_QUERY;
    r.query_lambda = q;
    push_item(r);
    counted_items++;
    // A query with no points returns nothing, so the event walk must be waited out.
    tail_cycles = (cur_points == 0) ? ((cur_events > N_EVENTS) ? N_EVENTS : cur_events)
                                      * EVENT_CYCLES : 0;
  endtask

  task automatic push_unused();
    clpr_req_t r;
    r          = rand_fields();
    r.req_type = REQ_UNUSED;
    push_item(r);
  endtask

  // Stop sending, wait for every owed label, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES + tail_cycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = CFG_DATA_W'(data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_cfg(idx, CFG_DATA_W'(data));
  endtask

  // Registers only change while the block is idle.
  task automatic configure(input int unsigned np, input int unsigned ne);
    drain();
    write_reg(CFG_NUM_POINTS, np);
    write_reg(CFG_NUM_EVENTS, ne);
    cur_points = np;
    cur_events = ne;
    settings_used++;
  endtask

  // Stimulus.
  initial begin : stimulus
    int unsigned               base_items;
    int unsigned               sel;
    int unsigned               np_new;
    int unsigned               ne_new;
    int unsigned               np_eff;
    int unsigned               seq_len;
    int unsigned               nq;
    int unsigned               prefix;
    int unsigned               s;
    int unsigned               e;
    bit                        reload;
    bit                        sentinel;
    logic [LAMBDA_W-1:0]       lam [$];
    logic [LAMBDA_W-1:0]       qs [$];

    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_NUM_POINTS;
    cfg_data_i    = '0;
    req_if.valid  = 1'b0;
    req_if.req_type        = REQ_LOAD_LABEL;
    req_if.point_index     = '0;
    req_if.label_value     = '0;
    req_if.event_index     = '0;
    req_if.event_lambda_in = '0;
    req_if.event_start_in  = '0;
    req_if.event_end_in    = '0;
    req_if.event_child_in  = '0;
    req_if.query_lambda    = '0;
    burst_left    = 0;
    calm          = 1'b0;
    counted_items = 0;
    tail_cycles   = 0;
    cur_points    = NUM_POINTS_RST;
    cur_events    = NUM_EVENTS_RST;
    settings_used = 0;
    quiet_cycles  = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Give every point a label first, so that no query reads an empty entry.
    for (int p = 0; p < int'(N_POINTS); p++) begin
      case (p)
        0:       load_label(p, 0);
        1:       load_label(p, 257);
        2:       load_label(p, 256);
        default: load_label(p, $urandom_range(0, 257));
      endcase
    end

    // Directed: single point, child ranges, last event as child, empty range and
    // a dead link, with queries on both sides of each event lambda.
    configure(64, 7);
    load_event(255, 32'h0000_1234, 64, 64, CHILD_SINGLE);
    load_event(0, 32'hFFFF_FFFF, 1, 1, CHILD_SINGLE);
    load_event(1, 32'h8000_0000, 3, 10, 10'd2);
    load_event(2, 32'h7000_0000, 60, 64, 10'd4);
    load_event(3, 32'h4000_0000, 64, 64, CHILD_SINGLE);
    load_event(4, 32'h1000_0000, 62, 3, 10'd256);
    load_event(5, 32'h0000_0002, 20, 9, 10'd5);
    load_event(6, 32'h0000_0001, 7, 7, CHILD_NO_LINK);
    query(32'hFFFF_FFFF);
    query(32'h7FFF_FFFF);
    query(32'h7000_0000);
    query(32'h0000_0001);
    query(32'h0000_0000);
    // Pointer already past the count: nothing more to apply.
    query(32'h0000_0000);
    // A load rewinds the pointer, so the whole path is replayed again.
    load_label(5, 100);
    query(32'h0000_0000);
    push_unused();
    query(32'hFFFF_FFFF);

    // One point only, and an event count beyond the table, stopped by a zero lambda.
    configure(1, 511);
    load_event(7, 32'h0000_0000, 1, 1, CHILD_SINGLE);
    query(32'h0000_0000);
    query(32'hFFFF_FFFF);

    // No points: events are applied but every write is dropped and nothing returns.
    configure(0, 8);
    load_label(0, 3);
    query(32'h0000_0000);

    // Too many points and no events.
    configure(127, 0);
    query($urandom());

    base_items = counted_items;

    // Random phases: mostly well-formed event paths with descending lambdas.
    while (counted_items < base_items + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        np_new = 0;
      end else if (sel < 3) begin
        np_new = 64;
      end else if (sel < 5) begin
        np_new = 1;
      end else if (sel == 5) begin
        np_new = $urandom_range(65, 127);
      end else begin
        np_new = $urandom_range(1, 64);
      end
      np_eff = (np_new == 0 || np_new > N_POINTS) ? N_POINTS : np_new;

      reload   = ($urandom_range(0, 6) != 0);
      sentinel = 1'b0;
      seq_len  = 0;
      if (reload) begin
        seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
          ne_new = seq_len;
        end else if (sel < 17) begin
          ne_new = $urandom_range(0, seq_len);
        end else begin
          // Count past the loaded path: a zero lambda at its end stops the walk.
          sentinel = 1'b1;
          case ($urandom_range(0, 2))
            0:       ne_new = 256;
            1:       ne_new = 511;
            default: ne_new = $urandom_range(seq_len + 1, 511);
          endcase
        end
      end else begin
        prefix = 0;
        while (prefix < N_EVENTS && ev_written[prefix]) prefix++;
        ne_new = $urandom_range(0, prefix);
      end

      configure(np_new, ne_new);
      calm = ($urandom_range(0, 3) == 0);

      if (reload) begin
        lam.delete();
        for (int k = 0; k < int'(seq_len); k++) lam.push_back($urandom());
        if ($urandom_range(0, 4) != 0) lam.rsort();
        if (sentinel) lam[seq_len-1] = '0;
        // Stray entry outside the path.
        if ($urandom_range(0, 3) == 0)
          load_event($urandom_range(seq_len, N_EVENTS - 1), $urandom(),
                     $urandom_range(1, 64), $urandom_range(1, 64), pick_child(seq_len));
        for (int k = 0; k < int'(seq_len); k++) begin
          s = ($urandom_range(0, 9) < 7) ? $urandom_range(1, np_eff) : $urandom_range(1, 64);
          e = ($urandom_range(0, 9) < 7) ? $urandom_range(s, 64) : $urandom_range(1, 64);
          load_event(k, lam[k], s, e, pick_child(seq_len));
        end
      end

      nq = $urandom_range(2, 6);
      qs.delete();
      for (int i = 0; i < int'(nq); i++) qs.push_back($urandom());
      if ($urandom_range(0, 4) != 0) qs.rsort();
      if ($urandom_range(0, 6) == 0) qs[0] = 32'hFFFF_FFFF;
      if ($urandom_range(0, 6) == 0) qs[nq-1] = 32'h0000_0000;
      for (int i = 0; i < int'(nq); i++) begin
        sel = $urandom_range(0, 19);
        if (sel < 3) begin
          load_label($urandom_range(0, N_POINTS - 1), $urandom_range(0, 257));
        end else if (sel == 3) begin
          push_unused();
        end
        query(qs[i]);
      end
    end

    drain();
    $display("Run covered %0d request items, %0d of them queries, over %0d register settings.",
             sb.requests_seen, sb.queries_seen, settings_used);
    $display("Checked %0d label items, %0d mismatches.", sb.labels_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
sv/clpr_pkg.sv
sv/clpr_req_if.sv
sv/clpr_res_if.sv
sv/clpr_label_mem.sv
sv/clpr_event_mem.sv
sv/clpr_out_buf.sv
sv/clpr_ctrl.sv
sv/cluster_label_path_replay_top.sv
tb/sv/tb.sv
